[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the packed byte converter.
// Synthesis builds define SYNTHESIS, which leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RWPB_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RWPB_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RWPB_ASSERT(name, clk, rst, prop, msg)
`define RWPB_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/rwpb_pkg.sv]
// Shared types, constants and helpers of the 10-bit sample byte packer.
// Used by the front, queue, back and top level modules; depends on nothing.
package rwpb_pkg;

  localparam int LEN_W = 13;
  localparam int IDX_W = 12;
  localparam int PIXEL_W = 32;
  localparam int SAMPLE_W = 10;
  localparam int PEND_W = 7;
  localparam int PEND_CNT_W = 3;
  localparam int BITS_W = 40;
  localparam int BYTE_W = 8;
  localparam int NBYTES_W = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [LEN_W-1:0] MAX_ROW_PIXELS = 13'd4096;
  localparam logic [LEN_W-1:0] MAX_FRAME_ROWS = 13'd4096;
  localparam logic [LEN_W-1:0] ROW_PIXELS_RESET = 13'd640;
  localparam logic [LEN_W-1:0] FRAME_ROWS_RESET = 13'd480;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PIXELS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One request as handed from the front to the back: the bit stream of the
  // pixel, left aligned and zero padded, with its byte count and row flags.
  typedef struct packed {
    logic [BITS_W-1:0]   bits;
    logic [NBYTES_W-1:0] nbytes;
    logic                row_end;
    logic                frame_end;
  } packet_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_status_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [LEN_W-1:0]       data;
  } cfg_req_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] max_len);
    if (v == '0) begin
      return {{(LEN_W-1){1'b0}}, 1'b1};
    end else if (v > max_len) begin
      return max_len;
    end
    return v;
  endfunction

endpackage

[hdl/rwpb_front.sv]
// Front end: takes configuration writes and pixel words, splits each pixel
// into samples, tracks row and frame position and builds one queue request.
// Depends on rwpb_pkg.
module rwpb_front import rwpb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_req_t            cfg,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic [PIXEL_W-1:0]  pixel_word,
  input  queue_status_t       q_status,
  output logic                push,
  output packet_t             push_entry
);

  logic [LEN_W-1:0]      row_pixels;
  logic [LEN_W-1:0]      frame_rows;
  logic [PEND_W-1:0]     pending_bits;
  logic [PEND_W-1:0]     pending_bits_next;
  logic [PEND_CNT_W-1:0] pending_count;
  logic [PEND_CNT_W-1:0] pending_count_next;
  logic [IDX_W-1:0]      column_index;
  logic [IDX_W-1:0]      row_index;

  logic [LEN_W-1:0]      row_len;
  logic [LEN_W-1:0]      frame_len;
  logic                  row_end;
  logic                  frame_end;
  logic [3*SAMPLE_W-1:0] samples;
  logic [5:0]            total;
  logic [2:0]            rem;
  logic                  pad;
  logic [BITS_W-1:0]     raw_bits;
  logic [PEND_W-1:0]     rem_mask;

  assign pixel_ready = q_status.not_full;
  assign push = pixel_valid && q_status.not_full;

  assign row_len = clamp_len(row_pixels, MAX_ROW_PIXELS);
  assign frame_len = clamp_len(frame_rows, MAX_FRAME_ROWS);
  assign row_end = ({1'b0, column_index} + 13'd1) >= row_len;
  assign frame_end = row_end && (({1'b0, row_index} + 13'd1) >= frame_len);

  assign samples = pixel_word[3*SAMPLE_W-1:0];
  assign total = {3'b000, pending_count} + 6'd30;
  assign rem = total[2:0];
  assign pad = row_end && (rem != 3'd0);
  assign raw_bits = {pending_bits, samples, 3'b000};
  assign rem_mask = 7'h7f >> (3'd7 - rem);

  always_comb begin
    push_entry.bits = raw_bits << (3'd7 - pending_count);
    push_entry.nbytes = total[5:3] + {2'b00, pad};
    push_entry.row_end = row_end;
    push_entry.frame_end = frame_end;
    if (row_end) begin
      pending_bits_next = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next = samples[PEND_W-1:0] & rem_mask;
      pending_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels <= ROW_PIXELS_RESET;
      frame_rows <= FRAME_ROWS_RESET;
      pending_bits <= '0;
      pending_count <= '0;
      column_index <= '0;
      row_index <= '0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == CFG_ROW_PIXELS) begin
          row_pixels <= cfg.data;
        end else if (cfg.index == CFG_FRAME_ROWS) begin
          frame_rows <= cfg.data;
        end
      end
      if (push) begin
        pending_bits <= pending_bits_next;
        pending_count <= pending_count_next;
        if (row_end) begin
          column_index <= '0;
          row_index <= frame_end ? '0 : row_index + 12'd1;
        end else begin
          column_index <= column_index + 12'd1;
        end
      end
    end
  end

endmodule

[hdl/rwpb_queue.sv]
// Short request queue between the front and the back of the byte packer.
// Depends on rwpb_pkg for the request type and the depth.
module rwpb_queue import rwpb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  packet_t       push_entry,
  input  logic          pop,
  output packet_t       head,
  output queue_status_t status
);

  packet_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign head = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.not_full = (count != QUEUE_CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/rwpb_back.sv]
// Back end: walks the head request of the queue into the output register
// one byte per cycle while out_ready does not stall it, and sets the item,
// row and frame end flags. Depends on rwpb_pkg.
module rwpb_back import rwpb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     q_status,
  input  packet_t           head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last_of_item,
  output logic              end_of_row,
  output logic              end_of_frame
);

  logic [NBYTES_W-1:0] byte_idx;
  logic [BYTE_W-1:0]   byte_sel;
  logic                take;
  logic                last_byte;

  assign take = q_status.not_empty && (!out_valid || out_ready);
  assign last_byte = (byte_idx == head.nbytes - 3'd1);
  assign pop = take && last_byte;

  always_comb begin
    unique case (byte_idx)
      3'd0:    byte_sel = head.bits[39:32];
      3'd1:    byte_sel = head.bits[31:24];
      3'd2:    byte_sel = head.bits[23:16];
      3'd3:    byte_sel = head.bits[15:8];
      default: byte_sel = head.bits[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= byte_sel;
      last_of_item <= last_byte;
      end_of_row <= last_byte && head.row_end;
      end_of_frame <= last_byte && head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        byte_idx <= last_byte ? '0 : byte_idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/rgb10_word_to_packed_bytes.sv]
// Top level of the 10-bit sample byte packer: front, request queue and back.
// Depends on rwpb_pkg, rwpb_front, rwpb_queue, rwpb_back and assert_macros.svh.
//
//   channel   direction  payload
//   cfg       in         cfg_index (register), cfg_data (13-bit value)
//   s_axis    in         tdata: pixel_word[31:0]
//   m_axis    out        tdata: out_byte; tlast: end_of_row;
//                        tuser: last_of_item, end_of_frame
//
// A pixel is accepted in any cycle in which the four-entry request queue has room.
// The output register sends one byte per cycle unless m_axis_tready stalls it;
// a pixel takes three to five bytes, 3.75 on average plus one padding byte at
// row end. A pixel's bytes pass through a queue entry and then the output register.
// Synchronous reset empties the queue, clears position and leftover bits and
// restores 640 pixels per row and 480 rows per frame. Output stalls fill the queue.
`include "assert_macros.svh"
module rgb10_word_to_packed_bytes import rwpb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIXEL_W-1:0]     s_axis_tdata,  // pixel_word[31:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [BYTE_W-1:0]      m_axis_tdata,  // out_byte[7:0]
  output logic                   m_axis_tlast,
  output logic [1:0]             m_axis_tuser   // [0] last_of_item, [1] end_of_frame
);

  cfg_req_t      cfg;
  queue_status_t q_status;
  logic          push;
  packet_t       push_entry;
  logic          pop;
  packet_t       head;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data = cfg_data;

  rwpb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (s_axis_tvalid),
    .pixel_ready (s_axis_tready),
    .pixel_word  (s_axis_tdata),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  rwpb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  rwpb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (m_axis_tdata),
    .last_of_item (m_axis_tuser[0]),
    .end_of_row   (m_axis_tlast),
    .end_of_frame (m_axis_tuser[1])
  );

  `RWPB_ASSERT_IMPLY(a_pop_needs_entry, clk, rst, pop, q_status.not_empty, "pop from empty queue")
  `RWPB_ASSERT_IMPLY(a_push_needs_room, clk, rst, push, q_status.not_full, "push into full queue")
  `RWPB_ASSERT_IMPLY(a_frame_end_flags, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0], "frame end without row end")
  `RWPB_ASSERT_IMPLY(a_row_end_is_item_end, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "row end before item end")

endmodule
